[src/sobs_pkg.sv]
// Shared types, sizes and codes for the bounded stacks block.
// No dependencies; imported by every module of the block.

package sobs_pkg;

    localparam int MAX_STACKS   = 16;
    localparam int MAX_CAPACITY = 16;

    localparam int SLOT_W      = (MAX_STACKS > 1) ? $clog2(MAX_STACKS) : 1;
    localparam int FILL_W      = $clog2(MAX_CAPACITY + 1);
    localparam int CNT_W       = $clog2(MAX_STACKS + 1);
    localparam int TOP_W       = (MAX_CAPACITY > 1) ? $clog2(MAX_CAPACITY) : 1;
    localparam int PLATE_DEPTH = MAX_STACKS * MAX_CAPACITY;
    localparam int PLATE_AW    = (PLATE_DEPTH > 1) ? $clog2(PLATE_DEPTH) : 1;

    localparam int DATA_W   = 32;
    localparam int IDX_W    = 8;
    localparam int CMD_W    = 2;
    localparam int STATUS_W = 2;
    localparam int CAP_W    = 5;
    localparam int APB_AW   = 3;
    localparam int APB_DW   = 32;

    localparam logic [DATA_W-1:0] NO_VALUE  = '1;
    localparam logic [CAP_W-1:0]  CAP_RESET = CAP_W'(2);

    // register index, taken from paddr[2]
    localparam logic REG_CAPACITY = 1'b0;

    typedef enum logic [CMD_W-1:0] {
        CMD_PUSH   = 2'd0,
        CMD_POP    = 2'd1,
        CMD_POP_AT = 2'd2
    } cmd_t;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK      = 2'd0,
        ST_EMPTY   = 2'd1,
        ST_DROPPED = 2'd2
    } status_t;

    typedef enum logic [2:0] {
        CELL_HOLD,
        CELL_INC,
        CELL_DEC,
        CELL_SHIFT,
        CELL_CLEAR
    } cell_op_t;

    typedef enum logic {
        S_IDLE,
        S_EXEC
    } fsm_state_t;

    typedef struct packed {
        logic [SLOT_W-1:0] slot;
        logic [FILL_W-1:0] fill;
    } cell_state_t;

    typedef struct packed {
        cell_op_t          op;
        logic [SLOT_W-1:0] freed_slot;
    } cell_ctl_t;

endpackage

[src/sobs_plate_ram.sv]
// Plate store: single-port RAM, one write or one read per cycle, registered read data.
// Depends on sobs_pkg.

module sobs_plate_ram
    import sobs_pkg::*;
(
    input  logic                aclk,
    input  logic                we,
    input  logic                re,
    input  logic [PLATE_AW-1:0] addr,
    input  logic [DATA_W-1:0]   wdata,
    output logic [DATA_W-1:0]   rdata
);

    logic [DATA_W-1:0] mem [PLATE_DEPTH];
    logic [DATA_W-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[addr] <= wdata;
        end
        if (re) begin
            rdata_reg <= mem[addr];
        end
    end

    assign rdata = rdata_reg;

endmodule

[src/sobs_cell.sv]
// One directory cell: slot number and fill count of one stack position.
// Takes its right neighbour's entry when the stack at or below its position is removed. Depends on sobs_pkg.

module sobs_cell
    import sobs_pkg::*;
(
    input  logic              aclk,
    input  logic              aresetn,
    input  logic [SLOT_W-1:0] reset_slot,
    input  cell_ctl_t         ctl,
    input  cell_state_t       right,
    output cell_state_t       state
);

    cell_state_t state_reg;
    cell_state_t state_next;

    always_comb begin
        state_next = state_reg;
        case (ctl.op)
            CELL_INC:   state_next.fill = state_reg.fill + FILL_W'(1);
            CELL_DEC:   state_next.fill = state_reg.fill - FILL_W'(1);
            CELL_SHIFT: state_next = right;
            CELL_CLEAR: begin
                state_next.slot = ctl.freed_slot;
                state_next.fill = '0;
            end
            default:    state_next = state_reg;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg.slot <= reset_slot;
            state_reg.fill <= '0;
        end else begin
            state_reg <= state_next;
        end
    end

    assign state = state_reg;

endmodule

[src/set_of_bounded_stacks.sv]
// Set of bounded stacks: top level with control, directory chain, plate RAM and APB port.
// Depends on sobs_pkg, sobs_cell and sobs_plate_ram.
//
// Usage:
//  - Input channel (s_*): one command per transfer: push s_push_value, pop the last
//    stack, or pop the stack at position s_stack_index.
//  - Result channel (m_*): exactly one result per command, in order: popped value
//    (all ones when nothing was removed) and status (ok, empty/bad index, dropped).
//  - Each command passes S_IDLE then S_EXEC: in the accept cycle the directory is consulted and
//    the plate RAM is read or written; in S_EXEC the result moves into the output register
//    once that register is free. The single RAM port and the registered read need this split.
//    A new command is taken only after the last result has moved into the output register.
//  - A finished result waits in the output register; the next command may be taken
//    meanwhile, but its result is held back until the waiting one has gone.
//  - The directory is a chain of cells, one per stack position; removing an emptied
//    stack moves every later cell down by one, all at once.
//  - Reset (aresetn low, synchronous): no stacks, capacity 2, directory slots in order.
//    The plate RAM is not cleared; no clearing pass is needed.
//  - APB register 0 (byte address 0): stack capacity, saturated to the maximum.
//    Written only while no stack exists; otherwise the write is ignored.

module set_of_bounded_stacks
    import sobs_pkg::*;
(
    input  logic                     aclk,
    input  logic                     aresetn,

    input  logic                     s_valid,
    output logic                     s_ready,
    input  logic [CMD_W-1:0]         s_cmd,
    input  logic signed [DATA_W-1:0] s_push_value,
    input  logic [IDX_W-1:0]         s_stack_index,

    output logic                     m_valid,
    input  logic                     m_ready,
    output logic signed [DATA_W-1:0] m_popped_value,
    output logic [STATUS_W-1:0]      m_status,

    input  logic                     psel,
    input  logic                     penable,
    input  logic                     pwrite,
    input  logic [APB_AW-1:0]        paddr,
    input  logic [APB_DW-1:0]        pwdata,
    output logic [APB_DW-1:0]        prdata,
    output logic                     pready
);

    // control state
    fsm_state_t        state_reg, state_next;
    logic [CNT_W-1:0]  cnt_reg, cnt_next;
    logic [FILL_W-1:0] cap_reg, cap_next;
    logic              pop_ok_reg, pop_ok_next;
    status_t           status_reg, status_next;

    // output register
    logic              m_valid_reg, m_valid_next;
    logic [DATA_W-1:0] m_value_reg, m_value_next;
    status_t           m_status_reg, m_status_next;

    // directory chain
    cell_state_t cell_st  [MAX_STACKS];
    cell_ctl_t   cell_ctl [MAX_STACKS];

    // plate RAM port
    logic                mem_we, mem_re;
    logic [PLATE_AW-1:0] mem_addr;
    logic [DATA_W-1:0]   mem_rdata;

    logic s_accept;
    logic load_out;
    logic cfg_write;

    assign s_accept = s_valid && s_ready;

    // ---------------- directory cells ----------------
    for (genvar q = 0; q < MAX_STACKS; q++) begin : g_cell
        cell_state_t right_st;
        if (q + 1 < MAX_STACKS) begin : g_mid
            assign right_st = cell_st[q+1];
        end else begin : g_end
            assign right_st = '0;
        end
        sobs_cell u_cell (
            .aclk       (aclk),
            .aresetn    (aresetn),
            .reset_slot (SLOT_W'(q)),
            .ctl        (cell_ctl[q]),
            .right      (right_st),
            .state      (cell_st[q])
        );
    end

    // ---------------- plate store ----------------
    sobs_plate_ram u_plate_ram (
        .aclk  (aclk),
        .we    (mem_we),
        .re    (mem_re),
        .addr  (mem_addr),
        .wdata (s_push_value),
        .rdata (mem_rdata)
    );

    // ---------------- command decode, done in the accept cycle ----------------
    logic [CNT_W-1:0]  cnt_m1;
    logic [SLOT_W-1:0] last_pos;
    logic [SLOT_W-1:0] pos;
    logic [FILL_W-1:0] last_fill;
    logic [FILL_W-1:0] sel_fill;
    logic [SLOT_W-1:0] sel_slot;
    logic [FILL_W-1:0] top_fill;
    logic              has_any, open_new, all_used, cap_zero;

    always_comb begin
        cnt_m1    = cnt_reg - CNT_W'(1);
        last_pos  = cnt_m1[SLOT_W-1:0];
        has_any   = (cnt_reg != '0);
        cap_zero  = (cap_reg == '0);
        all_used  = (cnt_reg == CNT_W'(MAX_STACKS));
        last_fill = cell_st[last_pos].fill;
        open_new  = !has_any || (last_fill >= cap_reg);

        case (s_cmd)
            CMD_PUSH:   pos = open_new ? cnt_reg[SLOT_W-1:0] : last_pos;
            CMD_POP_AT: pos = s_stack_index[SLOT_W-1:0];
            default:    pos = last_pos;
        endcase
        sel_slot = cell_st[pos].slot;
        sel_fill = cell_st[pos].fill;
    end

    always_comb begin
        cnt_next    = cnt_reg;
        pop_ok_next = pop_ok_reg;
        status_next = status_reg;
        mem_we      = 1'b0;
        mem_re      = 1'b0;
        top_fill    = '0;
        for (int q = 0; q < MAX_STACKS; q++) begin
            cell_ctl[q].op         = CELL_HOLD;
            cell_ctl[q].freed_slot = sel_slot;
        end

        if (s_accept) begin
            pop_ok_next = 1'b0;
            status_next = ST_EMPTY;
            case (s_cmd)
                CMD_PUSH: begin
                    if (cap_zero || (open_new && all_used)) begin
                        status_next = ST_DROPPED;
                    end else begin
                        status_next = ST_OK;
                        mem_we      = 1'b1;
                        top_fill    = open_new ? '0 : sel_fill;
                        cell_ctl[pos].op = CELL_INC;
                        if (open_new) begin
                            cnt_next = cnt_reg + CNT_W'(1);
                        end
                    end
                end
                CMD_POP, CMD_POP_AT: begin
                    if (!cap_zero && ((s_cmd == CMD_POP && has_any) ||
                        (s_cmd == CMD_POP_AT && s_stack_index < IDX_W'(cnt_reg)))) begin
                        status_next = ST_OK;
                        pop_ok_next = 1'b1;
                        mem_re      = 1'b1;
                        top_fill    = sel_fill - FILL_W'(1);
                        if (sel_fill == FILL_W'(1)) begin
                            // stack empties: close up the later positions
                            for (int q = 0; q < MAX_STACKS; q++) begin
                                if (q >= int'(pos) && q < int'(cnt_reg) - 1) begin
                                    cell_ctl[q].op = CELL_SHIFT;
                                end else if (q == int'(cnt_reg) - 1) begin
                                    cell_ctl[q].op = CELL_CLEAR;
                                end
                            end
                            cnt_next = cnt_m1;
                        end else begin
                            cell_ctl[pos].op = CELL_DEC;
                        end
                    end
                end
                default: status_next = ST_EMPTY;
            endcase
        end

        mem_addr = PLATE_AW'(int'(sel_slot) * MAX_CAPACITY + int'(top_fill[TOP_W-1:0]));
    end

    // ---------------- sequencer ----------------
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE:  if (s_accept) state_next = S_EXEC;
            S_EXEC:  if (load_out) state_next = S_IDLE;
            default: state_next = S_IDLE;
        endcase
    end

    always_comb begin
        s_ready  = 1'b0;
        load_out = 1'b0;
        case (state_reg)
            S_IDLE:  s_ready  = 1'b1;
            S_EXEC:  load_out = !m_valid_reg || m_ready;
            default: begin
                s_ready  = 1'b0;
                load_out = 1'b0;
            end
        endcase
    end

    // ---------------- output register ----------------
    always_comb begin
        m_valid_next  = m_valid_reg;
        m_value_next  = m_value_reg;
        m_status_next = m_status_reg;
        if (m_valid_reg && m_ready) begin
            m_valid_next = 1'b0;
        end
        if (load_out) begin
            m_valid_next  = 1'b1;
            m_value_next  = pop_ok_reg ? mem_rdata : NO_VALUE;
            m_status_next = status_reg;
        end
    end

    assign m_valid        = m_valid_reg;
    assign m_popped_value = m_value_reg;
    assign m_status       = m_status_reg;

    // ---------------- configuration port ----------------
    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && pready &&
                       (paddr[2] == REG_CAPACITY) && !has_any;

    always_comb begin
        cap_next = cap_reg;
        if (cfg_write) begin
            if (int'(pwdata[CAP_W-1:0]) > MAX_CAPACITY) begin
                cap_next = FILL_W'(MAX_CAPACITY);
            end else begin
                cap_next = FILL_W'(pwdata[CAP_W-1:0]);
            end
        end
    end

    always_comb begin
        prdata = '0;
        if (paddr[2] == REG_CAPACITY) begin
            prdata = APB_DW'(cap_reg);
        end
    end

    // ---------------- registers ----------------
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= S_IDLE;
            cnt_reg     <= '0;
            cap_reg     <= FILL_W'(CAP_RESET);
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            cnt_reg     <= cnt_next;
            cap_reg     <= cap_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        pop_ok_reg   <= pop_ok_next;
        status_reg   <= status_next;
        m_value_reg  <= m_value_next;
        m_status_reg <= m_status_next;
    end

endmodule
